[sv/binary_length_prefix_deframer_macros.svh]
// Assertion macros shared by the deframer RTL.
`ifndef BINARY_LENGTH_PREFIX_DEFRAMER_MACROS_SVH
`define BINARY_LENGTH_PREFIX_DEFRAMER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BLPD_ASSERT_IMP(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BLPD_ASSERT_NXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

[sv/blpd_pkg.sv]
// Types and constants shared by the length-prefixed deframer.
package blpd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 32;
  localparam int unsigned WordBytes = WordW / ByteW;
  localparam int unsigned CountW = $clog2(WordBytes);

  typedef enum logic [1:0] {
    PH_LENGTH = 2'd0,
    PH_IDENT  = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  typedef struct packed {
    logic [WordW-1:0] message_id;
    logic [ByteW-1:0] body_byte;
    logic             last_of_message;
    logic             drop_flag;
  } result_t;

  // Registered input byte handed to the parser.
  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data;
  } byte_stage_t;

  // Parser output toward the result register.
  typedef struct packed {
    logic    valid;
    result_t result;
  } result_stage_t;

endpackage

[sv/blpd_if.sv]
// Channel interfaces for the byte input and the result output.
interface blpd_in_if;
  logic                         valid;
  logic                         ready;
  logic [blpd_pkg::ByteW-1:0]   stream_byte;

  modport source(output valid, output stream_byte, input ready);
  modport sink(input valid, input stream_byte, output ready);
endinterface

interface blpd_out_if;
  logic                         valid;
  logic                         ready;
  logic [blpd_pkg::WordW-1:0]   message_id;
  logic [blpd_pkg::ByteW-1:0]   body_byte;
  logic                         last_of_message;
  logic                         drop_flag;

  modport source(output valid, output message_id, output body_byte,
                 output last_of_message, output drop_flag, input ready);
  modport sink(input valid, input message_id, input body_byte,
               input last_of_message, input drop_flag, output ready);
endinterface

[sv/blpd_in_stage.sv]
// Input register: holds one accepted byte until the parser consumes it.
module blpd_in_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [blpd_pkg::ByteW-1:0] in_byte,
  input  logic                       advance,
  output logic                       in_ready,
  output blpd_pkg::byte_stage_t      stage
);

  logic                       valid_r;
  logic [blpd_pkg::ByteW-1:0] data_r;

  assign in_ready = !valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_byte;
    end
  end

  assign stage.valid = valid_r;
  assign stage.data  = data_r;

endmodule

[sv/blpd_parser.sv]
// Frame parser: length, identifier and body phases, one byte per cycle if not stalled.
module blpd_parser (
  input  logic                    clk,
  input  logic                    rst_n,
  input  blpd_pkg::byte_stage_t   stage,
  input  logic                    take,
  output logic                    advance,
  output blpd_pkg::result_stage_t res
);

  localparam logic [blpd_pkg::CountW-1:0] LastCount =
    blpd_pkg::CountW'(blpd_pkg::WordBytes - 1);

  blpd_pkg::phase_t             phase_r, phase_nxt;
  logic [blpd_pkg::CountW-1:0]  count_r, count_nxt;
  logic [blpd_pkg::WordW-1:0]   len_r, len_nxt;
  logic [blpd_pkg::WordW-1:0]   rem_r, rem_nxt;
  logic [blpd_pkg::WordW-1:0]   id_r, id_nxt;

  logic                         last_field_byte;
  logic                         rem_last;
  logic [blpd_pkg::WordW-1:0]   len_shifted;

  assign last_field_byte = (count_r == LastCount);
  assign rem_last        = (rem_r == blpd_pkg::WordW'(1));
  assign len_shifted     = {len_r[blpd_pkg::WordW-blpd_pkg::ByteW-1:0], stage.data};

  // Consume the staged byte when it makes no result or the result register frees up.
  assign advance = stage.valid && (!res.valid || take);

  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    len_nxt    = len_r;
    rem_nxt    = rem_r;
    id_nxt     = id_r;
    res.valid  = 1'b0;
    res.result = '0;

    unique case (phase_r)
      blpd_pkg::PH_IDENT: begin
        id_nxt  = {id_r[blpd_pkg::WordW-blpd_pkg::ByteW-1:0], stage.data};
        rem_nxt = rem_r - blpd_pkg::WordW'(1);
        if (rem_last) begin
          // Payload ended inside the identifier: drop it.
          res.valid            = stage.valid;
          res.result.drop_flag = 1'b1;
          phase_nxt            = blpd_pkg::PH_LENGTH;
          count_nxt            = '0;
          len_nxt              = '0;
        end else if (last_field_byte) begin
          count_nxt = '0;
          phase_nxt = blpd_pkg::PH_BODY;
        end else begin
          count_nxt = count_r + blpd_pkg::CountW'(1);
        end
      end
      blpd_pkg::PH_BODY: begin
        rem_nxt                    = rem_r - blpd_pkg::WordW'(1);
        res.valid                  = stage.valid;
        res.result.message_id      = id_r;
        res.result.body_byte       = stage.data;
        res.result.last_of_message = rem_last;
        if (rem_last) begin
          phase_nxt = blpd_pkg::PH_LENGTH;
          count_nxt = '0;
          len_nxt   = '0;
        end
      end
      default: begin
        // Length field; an unused phase code is handled the same way.
        phase_nxt = blpd_pkg::PH_LENGTH;
        len_nxt   = len_shifted;
        if (last_field_byte) begin
          rem_nxt   = len_shifted;
          count_nxt = '0;
          len_nxt   = '0;
          if (len_shifted != '0) begin
            id_nxt    = '0;
            phase_nxt = blpd_pkg::PH_IDENT;
          end
        end else begin
          count_nxt = count_r + blpd_pkg::CountW'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= blpd_pkg::PH_LENGTH;
      count_r <= '0;
      len_r   <= '0;
      rem_r   <= '0;
      id_r    <= '0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      len_r   <= len_nxt;
      rem_r   <= rem_nxt;
      id_r    <= id_nxt;
    end
  end

endmodule

[sv/blpd_out_stage.sv]
// Result register: holds one result until the downstream side takes it.
module blpd_out_stage (
  input  logic                    clk,
  input  logic                    rst_n,
  input  blpd_pkg::result_stage_t res,
  input  logic                    load,
  input  logic                    out_ready,
  output logic                    take,
  output logic                    out_valid,
  output blpd_pkg::result_t       out_result
);

  logic              valid_r;
  blpd_pkg::result_t result_r;

  assign take = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load && res.valid) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.valid) begin
      result_r <= res.result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

[sv/binary_length_prefix_deframer.sv]
// Top level of the length-prefixed byte-stream deframer.
//
//   channel   direction  transaction payload
//   in_chan   sink       stream_byte (8)
//   out_chan  source     message_id (32), body_byte (8), last_of_message, drop_flag
//
// One byte per cycle while results are taken: input register, combinational parse logic,
// result register. An accepted byte waits in the input register, and its result is then
// loaded into the result register, from which the result transaction is made.
// Reset (rst_n low, synchronous) empties both registers and returns to the length phase.
// A stalled result holds the parser only while the staged byte makes a result; bytes
// that make none keep flowing, and in_chan.ready drops while a result-making byte waits.
`include "binary_length_prefix_deframer_macros.svh"

module binary_length_prefix_deframer (
  input logic        clk,
  input logic        rst_n,
  blpd_in_if.sink    in_chan,
  blpd_out_if.source out_chan
);

  blpd_pkg::byte_stage_t   stage;
  blpd_pkg::result_stage_t res;
  blpd_pkg::result_t       out_result;
  logic                    advance;
  logic                    take;
  logic                    drop_rest_zero;

  // Hold the byte until the parser can advance.
  blpd_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_byte  (in_chan.stream_byte),
    .advance  (advance),
    .in_ready (in_chan.ready),
    .stage    (stage)
  );

  // Advance the frame state once per consumed byte.
  blpd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .stage   (stage),
    .take    (take),
    .advance (advance),
    .res     (res)
  );

  // Load a result whenever the parser advances with one.
  blpd_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .load       (advance),
    .out_ready  (out_chan.ready),
    .take       (take),
    .out_valid  (out_chan.valid),
    .out_result (out_result)
  );

  assign out_chan.message_id      = out_result.message_id;
  assign out_chan.body_byte       = out_result.body_byte;
  assign out_chan.last_of_message = out_result.last_of_message;
  assign out_chan.drop_flag       = out_result.drop_flag;

  assign drop_rest_zero = (out_chan.message_id == '0) && (out_chan.body_byte == '0) &&
                          !out_chan.last_of_message;

  // A consumed byte with a result must show up at the output next cycle.
  `BLPD_ASSERT_NXT(a_result_lands, advance && res.valid, out_chan.valid, "result lost")
  // A drop result carries nothing else.
  `BLPD_ASSERT_IMP(a_drop_clean, out_chan.valid && out_chan.drop_flag, drop_rest_zero, "drop result not clean")
  // Back-pressure at the input only when a byte is already waiting.
  `BLPD_ASSERT_IMP(a_ready_low_full, !in_chan.ready, stage.valid && !advance, "input stalled while empty")

endmodule
